// ----- rtl/bba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, status codes and types for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int NUM_BLOCKS  = 32;
  localparam int POOL_BYTES  = NUM_BLOCKS * BLOCK_BYTES;
  localparam int IDX_W       = 5;
  localparam int ADDR_W      = 32;
  localparam int MAP_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int OUT_DATA_W  = 72;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  // lowest free block search result
  typedef struct packed {
    logic none;
    idx_t idx;
  } find_t;

  // free address decode result
  typedef struct packed {
    logic outside;
    logic misaligned;
    idx_t idx;
  } chk_t;

  // byte offset of a block from the pool base
  function automatic logic [ADDR_W-1:0] block_offset(input idx_t k);
    logic [ADDR_W-1:0] r;
    r = ADDR_W'(k) * ADDR_W'(BLOCK_BYTES);
    return r;
  endfunction

endpackage

// ----- rtl/bitmap_block_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// Allocator for 32 equal blocks tracked in a 32-bit free map (set = free).
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                          | tuser
// in_     | in  | address[31:0]                              | opcode
// out_    | out | blk_idx, block_address, free_map, pad      | status
// cfg_    | in  | pool_base (write only)                     | -
//
// one beat per cycle sustained while out_tready holds; a request passes
// the input register, then the result register, on its way to the output
// the free map is read and updated in the same cycle the result registers
// a stalled output holds the result and the input stage fills, then
// in_tready drops; reset makes every block free and pool_base zero
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bba_pkg::ADDR_W-1:0]        in_tdata,   // address
  input  logic                              in_tuser,   // opcode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // blk_idx[4:0], block_address[36:5], free_map[68:37], zero[71:69]
  output logic [bba_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [bba_pkg::STATUS_W-1:0]      out_tuser,  // status
  input  logic                              cfg_wr_en,
  input  logic [bba_pkg::ADDR_W-1:0]        cfg_wr_data
);

  logic                           s1_valid_r;
  logic                           s1_op_r;
  logic [bba_pkg::ADDR_W-1:0]     s1_addr_r;
  logic                           out_valid_r;
  logic [bba_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  bba_pkg::idx_t                  out_idx_r, out_idx_nxt;
  logic [bba_pkg::ADDR_W-1:0]     out_baddr_r, out_baddr_nxt;
  logic [bba_pkg::MAP_W-1:0]      free_map_r, free_map_nxt;
  logic [bba_pkg::ADDR_W-1:0]     pool_base_r;

  logic                           s2_ready;
  logic                           s1_fire;
  bba_pkg::find_t                 find_res;
  bba_pkg::chk_t                  chk_res;

  bba_find u_find (
    .free_map (free_map_r),
    .res      (find_res)
  );

  bba_addr_chk u_addr_chk (
    .addr      (s1_addr_r),
    .pool_base (pool_base_r),
    .res       (chk_res)
  );

  assign s2_ready  = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s2_ready;
  assign in_tready = !s1_valid_r || s2_ready;

  always_comb begin
    out_status_nxt = bba_pkg::ST_OK;
    out_idx_nxt    = '0;
    out_baddr_nxt  = '0;
    free_map_nxt   = free_map_r;
    if (s1_op_r == bba_pkg::OP_ALLOC) begin
      if (find_res.none) begin
        out_status_nxt = bba_pkg::ST_EXHAUSTED;
      end else begin
        out_idx_nxt   = find_res.idx;
        out_baddr_nxt = pool_base_r + bba_pkg::block_offset(find_res.idx);
        // block i lives at bit 31 - i, which is ~i on five bits
        free_map_nxt[~find_res.idx] = 1'b0;
      end
    end else begin
      if (chk_res.outside) begin
        out_status_nxt = bba_pkg::ST_OUTSIDE;
      end else if (chk_res.misaligned) begin
        out_status_nxt = bba_pkg::ST_MISALIGNED;
      end else begin
        out_idx_nxt = chk_res.idx;
        free_map_nxt[~chk_res.idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      free_map_r  <= '1;
      pool_base_r <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        free_map_r <= free_map_nxt;
      end
      if (cfg_wr_en) begin
        pool_base_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tuser;
      s1_addr_r <= in_tdata;
    end
    if (s1_fire) begin
      out_status_r <= out_status_nxt;
      out_idx_r    <= out_idx_nxt;
      out_baddr_r  <= out_baddr_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, free_map_r, out_baddr_r, out_idx_r};

  // the result map always matches the live map while a beat waits
  a_map_tracks : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[68:37] == free_map_r))
    else $error("result free map differs from live map");

  // errors report index zero and address zero
  a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != bba_pkg::ST_OK) |->
      (out_tdata[36:0] == '0))
    else $error("error result carries nonzero index or address");

  // one request changes at most one map bit
  a_one_bit : assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(free_map_r ^ $past(free_map_r)) <= 1))
    else $error("free map changed by more than one bit");

endmodule

// ----- rtl/bba_find.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_find
// Priority encoder: lowest-numbered free block, i.e. the leading set bit.
// ----------------------------------------------------------------------------
module bba_find (
  input  logic [bba_pkg::MAP_W-1:0] free_map,
  output bba_pkg::find_t            res
);

  always_comb begin
    res.none = (free_map == '0);
    res.idx  = '0;
    // walk from the highest index down so the lowest free index wins
    for (int i = bba_pkg::NUM_BLOCKS - 1; i >= 0; i--) begin
      if (free_map[bba_pkg::NUM_BLOCKS - 1 - i]) begin
        res.idx = bba_pkg::IDX_W'(i);
      end
    end
  end

endmodule

// ----- rtl/bba_addr_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_addr_chk
// Checks a free address against the pool bounds and block alignment and
// decodes it to a block index.
// ----------------------------------------------------------------------------
module bba_addr_chk (
  input  logic [bba_pkg::ADDR_W-1:0] addr,
  input  logic [bba_pkg::ADDR_W-1:0] pool_base,
  output bba_pkg::chk_t              res
);

  logic [bba_pkg::ADDR_W:0]          off;
  logic [bba_pkg::NUM_BLOCKS-1:0]    hit;
  logic                              outside;

  // top bit is the borrow: address below the base
  assign off = {1'b0, addr} - {1'b0, pool_base};

  assign outside = (addr == '0) || off[bba_pkg::ADDR_W] ||
                   (off[bba_pkg::ADDR_W-1:0] >= bba_pkg::ADDR_W'(bba_pkg::POOL_BYTES));

  // compare against every block start, at most one can hit
  always_comb begin
    for (int k = 0; k < bba_pkg::NUM_BLOCKS; k++) begin
      hit[k] = (off[bba_pkg::ADDR_W-1:0] ==
                bba_pkg::block_offset(bba_pkg::IDX_W'(k)));
    end
  end

  always_comb begin
    res.idx = '0;
    for (int k = 0; k < bba_pkg::NUM_BLOCKS; k++) begin
      if (hit[k]) begin
        res.idx = res.idx | bba_pkg::IDX_W'(k);
      end
    end
    res.outside    = outside;
    res.misaligned = !outside && (hit == '0);
    if (outside || hit == '0) begin
      res.idx = '0;
    end
  end

endmodule

// ----- verif/bitmap_block_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_tb
// Self-checking bench for the bitmap block allocator. Allocate and free
// requests stream in through a queue-fed driver. Each accepted beat is run
// through a local model of the free map and pool bounds, and the expected
// result is queued. The monitor checks each output beat field by field
// against the oldest expected result. Phases change pool_base and the idle
// and stall rates on both sides.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_tb;
  import bba_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOW_LIMIT  = 10;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] address;
  } alloc_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    idx_t                blk_idx;
    logic [ADDR_W-1:0]   block_address;
    logic [MAP_W-1:0]    free_map;
  } alloc_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [ADDR_W-1:0]     in_tdata = '0;    // address
  logic                  in_tuser = 1'b0;  // opcode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // blk_idx[4:0], block_address[36:5], free_map[68:37], zero[71:69]
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;        // status
  logic                  cfg_wr_en = 1'b0;
  logic [ADDR_W-1:0]     cfg_wr_data = '0;

  alloc_req_t    request_q[$];
  alloc_result_t pending_results[$];

  logic [MAP_W-1:0]  map_model = '1;
  logic [ADDR_W-1:0] pool_model = '0;
  logic [ADDR_W-1:0] pool_cfg = '0;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int accepted_cnt = 0;
  int checked_cnt = 0;
  int cycle_cnt = 0;
  int mismatch_cnt = 0;
  logic in_taken = 1'b0;

  bitmap_block_allocator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // applies one request to the model free map and returns the expected beat
  function automatic alloc_result_t apply_request(input logic op, input logic [ADDR_W-1:0] addr);
    alloc_result_t r;
    logic [ADDR_W:0] off;
    logic found;
    r = '0;
    r.status = ST_OK;
    found = 1'b0;
    if (op == OP_ALLOC) begin
      if (map_model == '0) begin
        r.status = ST_EXHAUSTED;
      end else begin
        // lowest-numbered free block sits at the highest set bit
        for (int i = 0; i < NUM_BLOCKS; i++) begin
          if (!found && map_model[MAP_W-1-i]) begin
            found = 1'b1;
            r.blk_idx = idx_t'(i);
          end
        end
        map_model[MAP_W-1-r.blk_idx] = 1'b0;
        r.block_address = pool_model + ADDR_W'(r.blk_idx) * ADDR_W'(BLOCK_BYTES);
      end
    end else begin
      off = {1'b0, addr} - {1'b0, pool_model};
      if (addr == '0 || addr < pool_model || off >= (ADDR_W+1)'(POOL_BYTES)) begin
        r.status = ST_OUTSIDE;
      end else if (off % (ADDR_W+1)'(BLOCK_BYTES) != 0) begin
        r.status = ST_MISALIGNED;
      end else begin
        r.blk_idx = idx_t'(off / (ADDR_W+1)'(BLOCK_BYTES));
        map_model[MAP_W-1-r.blk_idx] = 1'b1;
      end
    end
    r.free_map = map_model;
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    mismatch_cnt++;
    if (mismatch_cnt <= SHOW_LIMIT) begin
      $display("mismatch on %s at cycle %0d: expected %08h, got %08h",
               field, cycle_cnt, exp_v, got_v);
    end
  endtask

  // request driver: holds a beat until it is taken, then maybe idles
  always @(negedge clk) begin : drive_requests
    alloc_req_t req;
    logic go;
    if (rst_n && (!in_tvalid || in_taken)) begin
      go = (request_q.size() > 0) && ($urandom_range(0, 99) >= src_idle_pct);
      if (go) begin
        req = request_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= req.address;
        in_tuser  <= req.opcode;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  // monitor: checks result beats, predicts on request beats
  always @(posedge clk) begin : watch_ports
    alloc_result_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      in_taken <= in_tvalid && in_tready && rst_n;
      if (!rst_n) begin
        map_model = '1;
        pool_model = '0;
      end else begin
        // check the output first so a same-edge prediction never matches it
        if (out_tvalid && out_tready) begin
          checked_cnt <= checked_cnt + 1;
          if (pending_results.size() == 0) begin
            note_mismatch("unexpected beat", '0, out_tdata[36:5]);
          end else begin
            want = pending_results.pop_front();
            if (out_tuser != want.status)
              note_mismatch("status", 32'(want.status), 32'(out_tuser));
            if (out_tdata[4:0] != want.blk_idx)
              note_mismatch("blk_idx", 32'(want.blk_idx), 32'(out_tdata[4:0]));
            if (out_tdata[36:5] != want.block_address)
              note_mismatch("block_address", want.block_address, out_tdata[36:5]);
            if (out_tdata[68:37] != want.free_map)
              note_mismatch("free_map", want.free_map, out_tdata[68:37]);
          end
        end
        if (cfg_wr_en)
          pool_model = cfg_wr_data;
        if (in_tvalid && in_tready) begin
          pending_results.push_back(apply_request(in_tuser, in_tdata));
          accepted_cnt <= accepted_cnt + 1;
        end
      end
    end
  end

  task automatic push_request(input logic op, input logic [ADDR_W-1:0] addr);
    alloc_req_t req;
    req.opcode  = op;
    req.address = addr;
    request_q.push_back(req);
  endtask

  // counters are read at the rising edge, before that edge's updates land
  task automatic wait_for_drain();
    @(posedge clk);
    while (!(request_q.size() == 0 && !in_tvalid && accepted_cnt == checked_cnt))
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic start_phase(input logic [ADDR_W-1:0] base, input int src_pct,
                             input int snk_pct);
    wait_for_drain();
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= base;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    pool_cfg      = base;
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  // mostly well-formed traffic around the current pool, with alloc bursts
  // so the map runs dry now and then
  task automatic queue_random_requests(input int n);
    int i;
    int roll;
    logic [ADDR_W-1:0] slot;
    i = 0;
    while (i < n) begin
      if (i % 100 == 0 && i + 34 <= n) begin
        repeat (34) push_request(OP_ALLOC, $urandom);
        i += 34;
      end else begin
        roll = $urandom_range(0, 99);
        slot = pool_cfg + ADDR_W'($urandom_range(0, NUM_BLOCKS - 1)) * ADDR_W'(BLOCK_BYTES);
        if (roll < 48)
          push_request(OP_ALLOC, $urandom);
        else if (roll < 78)
          push_request(OP_FREE, slot);
        else if (roll < 86)
          push_request(OP_FREE, slot + ADDR_W'($urandom_range(1, BLOCK_BYTES - 1)));
        else if (roll < 90)
          push_request(OP_FREE, pool_cfg - ADDR_W'($urandom_range(1, 128)));
        else if (roll < 94)
          push_request(OP_FREE, pool_cfg + ADDR_W'(POOL_BYTES) + ADDR_W'($urandom_range(0, 128)));
        else if (roll < 97)
          push_request(OP_FREE, '0);
        else
          push_request(OP_FREE, $urandom);
        i++;
      end
    end
  endtask

  initial begin : run_test
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    start_phase(32'h0000_0000, 0, 0);
    push_request(OP_ALLOC, 32'h0000_0000);
    push_request(OP_ALLOC, 32'hFFFF_FFFF);
    push_request(OP_FREE,  32'h0000_0000);  // address zero is always outside
    push_request(OP_FREE,  32'h0000_0040);
    push_request(OP_FREE,  32'h0000_0040);  // double free
    push_request(OP_FREE,  32'h0000_0041);
    push_request(OP_FREE,  32'h0000_07FF);
    push_request(OP_FREE,  32'h0000_0800);
    push_request(OP_FREE,  32'h0000_07C0);
    push_request(OP_FREE,  32'hFFFF_FFFF);
    push_request(OP_FREE,  32'h8000_0000);
    push_request(OP_ALLOC, 32'h5555_5555);
    push_request(OP_ALLOC, 32'hAAAA_AAAA);
    push_request(OP_FREE,  32'h0000_0080);
    push_request(OP_FREE,  32'h0000_0000);
    queue_random_requests(130);

    // pool runs past the top of the address space
    start_phase(32'hFFFF_FFC0, 73, 0);
    push_request(OP_FREE, 32'hFFFF_FFBF);
    push_request(OP_FREE, 32'hFFFF_FFC0);
    queue_random_requests(120);

    start_phase(32'hFFFF_FFFF, 0, 73);
    queue_random_requests(120);

    start_phase($urandom, 8, 8);
    queue_random_requests(130);

    start_phase(32'hFFFF_F800, 0, 0);
    queue_random_requests(130);

    wait_for_drain();
    repeat (8) @(negedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/bba_pkg.sv
rtl/bba_find.sv
rtl/bba_addr_chk.sv
rtl/bitmap_block_allocator.sv
verif/bitmap_block_allocator_tb.sv
